/* rtl/generational_handle_allocator_unit_defines.svh */
// Assertion macros shared by the allocator checker.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define GHA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed: implication violated");

// The consequent must follow the antecedent, checked at a delay set in the property.
`define GHA_ASSERT_AFTER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("allocator check failed: missing response");

`endif

/* rtl/gha_pkg.sv */
// Shared constants, codes and interface types of the handle allocator.
package gha_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int HEAD_W    = SLOT_W + 1;
   localparam int VER_W     = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef struct packed {
      logic [SLOT_W-1:0] link_addr;
      logic [SLOT_W-1:0] ver_addr;
   } rd_addr_type;

   typedef struct packed {
      logic [HEAD_W-1:0] link;
      logic [VER_W-1:0]  version;
   } rd_data_type;

   typedef struct packed {
      logic              link_we;
      logic [SLOT_W-1:0] link_addr;
      logic [HEAD_W-1:0] link_data;
      logic              ver_we;
      logic [SLOT_W-1:0] ver_addr;
      logic [VER_W-1:0]  ver_data;
   } wr_cmd_type;

endpackage

/* rtl/gha_store.sv */
// Link and version stores with registered reads and same-edge write forwarding.
module gha_store (
   input  logic               clock,
   input  logic               reset,
   input  gha_pkg::rd_addr_type rd_addr,
   input  gha_pkg::wr_cmd_type  wr_cmd,
   output gha_pkg::rd_data_type rd_data
);
   import gha_pkg::*;

   logic [HEAD_W-1:0] link_mem [MAX_SLOTS];
   logic [VER_W-1:0]  ver_mem  [MAX_SLOTS];

   logic [HEAD_W-1:0] link_q_ff;
   logic [VER_W-1:0]  ver_q_ff;
   logic [HEAD_W-1:0] link_fwd_ff;
   logic [VER_W-1:0]  ver_fwd_ff;
   logic              link_hit_ff;
   logic              ver_hit_ff;
   logic              link_hit_in;
   logic              ver_hit_in;

   // A write landing on the edge of a read at the same address is not seen
   // by the array read, so it is captured and substituted.
   assign link_hit_in = wr_cmd.link_we && (wr_cmd.link_addr == rd_addr.link_addr);
   assign ver_hit_in  = wr_cmd.ver_we && (wr_cmd.ver_addr == rd_addr.ver_addr);

   always_ff @(posedge clock) begin
      if (wr_cmd.link_we) begin
         link_mem[wr_cmd.link_addr] <= wr_cmd.link_data;
      end
      if (wr_cmd.ver_we) begin
         ver_mem[wr_cmd.ver_addr] <= wr_cmd.ver_data;
      end
      link_q_ff   <= link_mem[rd_addr.link_addr];
      ver_q_ff    <= ver_mem[rd_addr.ver_addr];
      link_fwd_ff <= wr_cmd.link_data;
      ver_fwd_ff  <= wr_cmd.ver_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_hit_ff <= 1'b0;
         ver_hit_ff  <= 1'b0;
      end else begin
         link_hit_ff <= link_hit_in;
         ver_hit_ff  <= ver_hit_in;
      end
   end

   assign rd_data.link    = link_hit_ff ? link_fwd_ff : link_q_ff;
   assign rd_data.version = ver_hit_ff ? ver_fwd_ff : ver_q_ff;

endmodule

/* rtl/gha_ctrl.sv */
// Request register, free-list head and fill state, and the result register.
module gha_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         req_op,
   input  logic [gha_pkg::SLOT_W-1:0]   req_free_index,
   input  gha_pkg::rd_data_type         rd_data,
   output gha_pkg::rd_addr_type         rd_addr,
   output gha_pkg::wr_cmd_type          wr_cmd,
   output logic                         rsp_strobe,
   output logic [gha_pkg::SLOT_W-1:0]   rsp_handle_index,
   output logic [gha_pkg::VER_W-1:0]    rsp_handle_version,
   output logic [1:0]                   rsp_status
);
   import gha_pkg::*;

   logic              stage_valid_ff;
   logic              stage_op_ff;
   logic [SLOT_W-1:0] stage_index_ff;
   logic [HEAD_W-1:0] head_ff;
   logic [HEAD_W-1:0] head_in;
   logic [HEAD_W-1:0] used_ff;
   logic [HEAD_W-1:0] used_in;

   logic              rsp_strobe_ff;
   logic [SLOT_W-1:0] rsp_index_ff;
   logic [SLOT_W-1:0] rsp_index_in;
   logic [VER_W-1:0]  rsp_version_ff;
   logic [VER_W-1:0]  rsp_version_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;

   always_comb begin
      head_in        = head_ff;
      used_in        = used_ff;
      wr_cmd         = '0;
      rsp_index_in   = '0;
      rsp_version_in = '0;
      rsp_status_in  = STATUS_OK;
      if (stage_valid_ff) begin
         if (stage_op_ff == OP_ALLOC) begin
            if (head_ff < HEAD_W'(MAX_SLOTS)) begin
               // Pop the list head; its link and version were read at accept.
               rsp_index_in   = head_ff[SLOT_W-1:0];
               rsp_version_in = rd_data.version;
               head_in        = rd_data.link;
            end else if (used_ff >= HEAD_W'(MAX_SLOTS - 1)) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               wr_cmd.ver_we   = 1'b1;
               wr_cmd.ver_addr = used_ff[SLOT_W-1:0];
               wr_cmd.ver_data = '0;
               used_in         = used_ff + HEAD_W'(1);
               rsp_index_in    = used_ff[SLOT_W-1:0];
            end
         end else begin
            if ({1'b0, stage_index_ff} >= used_ff) begin
               rsp_status_in = STATUS_BAD_FREE;
            end else begin
               wr_cmd.link_we   = 1'b1;
               wr_cmd.link_addr = stage_index_ff;
               wr_cmd.link_data = head_ff;
               wr_cmd.ver_we    = 1'b1;
               wr_cmd.ver_addr  = stage_index_ff;
               wr_cmd.ver_data  = rd_data.version + VER_W'(1);
               head_in          = {1'b0, stage_index_ff};
            end
         end
      end
   end

   // Reads are addressed with the head as it stands after the item now in
   // the stage, so the next item sees the list it leaves behind.
   assign rd_addr.link_addr = head_in[SLOT_W-1:0];
   assign rd_addr.ver_addr  = (req_op == OP_FREE) ? req_free_index : head_in[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         head_ff        <= HEAD_W'(MAX_SLOTS);
         used_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         stage_valid_ff <= start;
         head_ff        <= head_in;
         used_ff        <= used_in;
         rsp_strobe_ff  <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         stage_op_ff    <= req_op;
         stage_index_ff <= req_free_index;
      end
      rsp_index_ff   <= rsp_index_in;
      rsp_version_ff <= rsp_version_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_handle_index   = rsp_index_ff;
   assign rsp_handle_version = rsp_version_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

/* rtl/generational_handle_allocator_unit.sv */
// Top level of the generational handle allocator.
// An accepted item passes the request stage and then the result register before its strobe.
// Throughput: one item per cycle; busy stays low, so start may be held every cycle.
// The registered link read of the free list is covered by addressing the stores with
// the head that the item in flight leaves, plus forwarding of same-edge writes.
// Synchronous reset empties the free list and the fill count; stores need no clearing.
module generational_handle_allocator_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_op,
   input  logic [gha_pkg::SLOT_W-1:0] req_free_index,
   output logic                       rsp_strobe,
   output logic [gha_pkg::SLOT_W-1:0] rsp_handle_index,
   output logic [gha_pkg::VER_W-1:0]  rsp_handle_version,
   output logic [1:0]                 rsp_status
);
   import gha_pkg::*;

   rd_addr_type rd_addr;
   rd_data_type rd_data;
   wr_cmd_type  wr_cmd;

   // Every item finishes in a single pass and the receiver cannot stall, so
   // the block never holds off a request.
   assign busy = 1'b0;

   // The controller owns the request stage, the free-list head, the count of
   // slots ever handed out and the result register. An allocate pops the head
   // or hands out the next fresh slot with version zero, else reports full; a
   // free of a slot handed out pushes it and bumps its version, else is refused.
   gha_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_op             (req_op),
      .req_free_index     (req_free_index),
      .rd_data            (rd_data),
      .rd_addr            (rd_addr),
      .wr_cmd             (wr_cmd),
      .rsp_strobe         (rsp_strobe),
      .rsp_handle_index   (rsp_handle_index),
      .rsp_handle_version (rsp_handle_version),
      .rsp_status         (rsp_status)
   );

   // The stores hold one link and one version per slot. Each is read once
   // and written at most once per cycle.
   gha_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr_cmd  (wr_cmd),
      .rd_data (rd_data)
   );

endmodule

/* rtl/gha_checker.sv */
// Port-level checker for the handle allocator and its bind statement.
`include "generational_handle_allocator_unit_defines.svh"

module gha_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       req_op,
   input logic [gha_pkg::SLOT_W-1:0] req_free_index,
   input logic                       rsp_strobe,
   input logic [gha_pkg::SLOT_W-1:0] rsp_handle_index,
   input logic [gha_pkg::VER_W-1:0]  rsp_handle_version,
   input logic [1:0]                 rsp_status
);
   import gha_pkg::*;

   logic accept;
   assign accept = start && !busy;

   `GHA_ASSERT_AFTER2(a_every_item_answered, clock, reset, accept, rsp_strobe)
   `GHA_ASSERT_IMPLIES(a_no_spurious_result, clock, reset, rsp_strobe, $past(accept, 2))
   `GHA_ASSERT_IMPLIES(a_error_clears_handle, clock, reset, rsp_strobe && rsp_status != STATUS_OK, rsp_handle_index == '0 && rsp_handle_version == '0)
   `GHA_ASSERT_IMPLIES(a_bad_free_from_free, clock, reset, rsp_strobe && rsp_status == STATUS_BAD_FREE, $past(req_op, 2) == OP_FREE)
   `GHA_ASSERT_IMPLIES(a_full_from_alloc, clock, reset, rsp_strobe && rsp_status == STATUS_FULL, $past(req_op, 2) == OP_ALLOC)

endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (.*);

/* verif/generational_handle_allocator_unit_tb.sv */
// Self-checking testbench for the generational handle allocator unit.
`timescale 1ns / 100ps

module generational_handle_allocator_unit_tb;
   import gha_pkg::*;

   // Cycles without any accepted item or result before the run is declared hung.
   localparam int HANG_LIMIT = 400;

   // One result item as the block reports it.
   typedef struct {
      logic [SLOT_W-1:0] index;
      logic [VER_W-1:0]  version;
      status_type        status;
   } handle_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_op;
   logic [SLOT_W-1:0] req_free_index;
   logic              rsp_strobe;
   logic [SLOT_W-1:0] rsp_handle_index;
   logic [VER_W-1:0]  rsp_handle_version;
   logic [1:0]        rsp_status;

   generational_handle_allocator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_free_index     (req_free_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_handle_index   (rsp_handle_index),
      .rsp_handle_version (rsp_handle_version),
      .rsp_status         (rsp_status)
   );

   // 12 ns clock period.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the allocator state. The head and the fill count are one bit
   // wider than a slot index so that MAX_SLOTS can stand for an empty free list.
   logic [HEAD_W-1:0] shadow_head;
   logic [HEAD_W-1:0] shadow_used;
   logic [HEAD_W-1:0] shadow_link [MAX_SLOTS];
   logic [VER_W-1:0]  shadow_version [MAX_SLOTS];

   // Handles predicted but not yet seen on the result port, oldest first.
   handle_type pending_handles [$];

   // Slots that the stimulus currently holds; used to build well-formed frees.
   int live_slots [$];

   int error_count = 0;
   int hang_cycles = 0;
   int burst_left  = 0;

   // Computes the handle that one accepted item produces and advances the shadow
   // state exactly as the block does.
   function automatic handle_type predict_handle(logic op, logic [SLOT_W-1:0] idx);
      handle_type res;
      res.index   = '0;
      res.version = '0;
      res.status  = STATUS_OK;
      if (op == OP_ALLOC) begin
         if (int'(shadow_head) < MAX_SLOTS) begin
            // Pop the head of the free list and reuse its stored version.
            res.index   = shadow_head[SLOT_W-1:0];
            res.version = shadow_version[shadow_head[SLOT_W-1:0]];
            shadow_head = shadow_link[shadow_head[SLOT_W-1:0]];
         end else if (int'(shadow_used) + 1 >= MAX_SLOTS) begin
            // The last index is never handed out, so capacity is one short.
            res.status = STATUS_FULL;
         end else begin
            shadow_version[shadow_used[SLOT_W-1:0]] = '0;
            res.index   = shadow_used[SLOT_W-1:0];
            shadow_used = shadow_used + HEAD_W'(1);
         end
      end else begin
         if (HEAD_W'(idx) >= shadow_used) begin
            res.status = STATUS_BAD_FREE;
         end else begin
            // Push the slot and bump its generation; wraps at the version width.
            shadow_link[idx]    = shadow_head;
            shadow_version[idx] = shadow_version[idx] + VER_W'(1);
            shadow_head         = HEAD_W'(idx);
         end
      end
      return res;
   endfunction

   // Drives one item, waits for the handshake, records the expected handle and
   // keeps the list of held slots current. The caller decides whether start drops.
   task automatic send_item(input logic op, input logic [SLOT_W-1:0] idx,
                            output handle_type predicted);
      start          <= 1'b1;
      req_op         <= op;
      req_free_index <= idx;
      do @(posedge clock); while (busy);
      predicted = predict_handle(op, idx);
      pending_handles.insert(pending_handles.size(), predicted);
      if (predicted.status == STATUS_OK) begin
         if (op == OP_ALLOC) begin
            live_slots.insert(live_slots.size(), int'(predicted.index));
         end else begin
            for (int i = 0; i < live_slots.size(); i++) begin
               if (live_slots[i] == int'(idx)) begin
                  live_slots.delete(i);
                  break;
               end
            end
         end
      end
   endtask

   // Sender pacing: bursts of random length separated by short random gaps.
   // Some bursts are long so that back-to-back traffic is exercised as well.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         if ($urandom_range(0, 9) == 0)
            burst_left = $urandom_range(100, 300);
         else
            burst_left = $urandom_range(0, 30);
      end
   endtask

   // Stops sending and waits until every expected handle has been reported.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_handles.size() != 0) @(posedge clock);
   endtask

   // Frees one randomly chosen held slot, if any is held.
   task automatic free_random_live();
      handle_type r;
      int k;
      if (live_slots.size() > 0) begin
         k = $urandom_range(0, live_slots.size() - 1);
         send_item(OP_FREE, SLOT_W'(live_slots[k]), r);
      end
   endtask

   // Short directed sequence: fresh slots, reuse with raised version, LIFO order
   // of the free list, frees of slots never handed out at the boundary and at the
   // top of the index range, and allocations that carry a stray free index.
   task automatic test_directed();
      handle_type r;
      send_item(OP_ALLOC, '0, r);
      send_item(OP_ALLOC, '0, r);
      send_item(OP_ALLOC, '0, r);
      send_item(OP_FREE, SLOT_W'(1), r);
      send_item(OP_ALLOC, '0, r);
      send_item(OP_FREE, SLOT_W'(3), r);      // equal to the fill count: refused
      send_item(OP_FREE, '1, r);              // top index, never handed out
      send_item(OP_FREE, SLOT_W'(0), r);
      send_item(OP_FREE, SLOT_W'(2), r);
      send_item(OP_ALLOC, '0, r);             // most recently freed comes back first
      send_item(OP_ALLOC, '0, r);
      send_item(OP_ALLOC, '1, r);             // list empty again, free index ignored
      send_item(OP_FREE, SLOT_W'(0), r);
      send_item(OP_ALLOC, SLOT_W'(10'h2AA), r);
      send_item(OP_FREE, SLOT_W'(10'h155), r);
      send_item(OP_FREE, SLOT_W'(3), r);
      send_item(OP_FREE, SLOT_W'(2), r);
      send_item(OP_ALLOC, '0, r);
      send_item(OP_ALLOC, '0, r);
      send_item(OP_ALLOC, '0, r);
      drain_results();
   endtask

   // Mixed traffic: mostly allocations and frees of held slots, with some frees
   // of slots that were never handed out. Halfway through the sender waits for
   // all outstanding results before carrying on.
   task automatic test_random_traffic(input int count);
      handle_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55 || live_slots.size() == 0)
            send_item(OP_ALLOC, SLOT_W'($urandom), r);
         else if (pick < 90)
            free_random_live();
         else
            send_item(OP_FREE, SLOT_W'($urandom_range(int'(shadow_used), MAX_SLOTS - 1)), r);
         if (n == count / 2)
            drain_results();
         else
            pace_sender();
      end
      drain_results();
   endtask

   // Allocates until the block refuses several times, probes both sides of the
   // fill boundary with frees, then releases part of the held slots in random
   // order with some allocations mixed in, and finally reuses the free list.
   task automatic test_fill_and_release();
      handle_type r;
      int refusals;
      refusals = 0;
      while (refusals < 4) begin
         send_item(OP_ALLOC, SLOT_W'($urandom), r);
         if (r.status == STATUS_FULL) refusals++;
         pace_sender();
      end
      send_item(OP_FREE, '1, r);              // never handed out even when full
      send_item(OP_FREE, SLOT_W'(MAX_SLOTS - 2), r);
      send_item(OP_ALLOC, '0, r);
      send_item(OP_ALLOC, '0, r);             // list empty and full again
      pace_sender();
      for (int n = 0; n < 40 && live_slots.size() > 0; n++) begin
         if ($urandom_range(0, 4) == 0)
            send_item(OP_ALLOC, SLOT_W'($urandom), r);
         else
            free_random_live();
         pace_sender();
      end
      for (int n = 0; n < 20; n++) begin
         send_item(OP_ALLOC, SLOT_W'($urandom), r);
         pace_sender();
      end
      drain_results();
   endtask

   // A slot freed twice links to itself, so it is handed out over and over and
   // each further free raises its version again. The list never empties after
   // this test.
   task automatic test_double_free();
      handle_type r;
      logic [SLOT_W-1:0] slot;
      if (live_slots.size() == 0) send_item(OP_ALLOC, '0, r);
      if (live_slots.size() > 0) begin
         slot = SLOT_W'(live_slots[live_slots.size() - 1]);
         send_item(OP_FREE, slot, r);
         send_item(OP_FREE, slot, r);         // double free goes unnoticed
         send_item(OP_ALLOC, '0, r);
         send_item(OP_ALLOC, '0, r);          // same slot handed out again
         pace_sender();
         for (int n = 0; n < 8; n++) begin
            send_item(OP_FREE, slot, r);
            if (n % 2 == 0) send_item(OP_ALLOC, SLOT_W'($urandom), r);
            pace_sender();
         end
         send_item(OP_ALLOC, '0, r);
         send_item(OP_FREE, SLOT_W'(0), r);
         send_item(OP_ALLOC, '0, r);
         send_item(OP_ALLOC, '0, r);
      end
      drain_results();
   endtask

   // Result checker: each strobe is matched against the oldest expected handle.
   always @(posedge clock) begin
      handle_type want;
      if (!reset && rsp_strobe) begin
         if (pending_handles.size() == 0) begin
            $error("unexpected result: index %0d version %0d status %0d",
                   rsp_handle_index, rsp_handle_version, rsp_status);
            error_count++;
         end else begin
            want = pending_handles.pop_front();
            if (rsp_handle_index !== want.index) begin
               $error("handle_index: expected %0d, actual %0d", want.index, rsp_handle_index);
               error_count++;
            end
            if (rsp_handle_version !== want.version) begin
               $error("handle_version: expected %0d, actual %0d",
                      want.version, rsp_handle_version);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // Counts cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         hang_cycles <= 0;
      else
         hang_cycles <= hang_cycles + 1;
   end

   // Watchdog: a hung block ends the run with a failure.
   initial begin
      while (hang_cycles < HANG_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      // Every input holds a known value from time zero.
      start          = 1'b0;
      req_op         = OP_ALLOC;
      req_free_index = '0;
      reset          = 1'b1;
      shadow_head    = HEAD_W'(MAX_SLOTS);
      shadow_used    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(100);
      test_fill_and_release();
      test_double_free();

      // Everything has been reported; let the block run on so that any stray
      // result shows before the verdict.
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_handles.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
